// ===== src/pdfe_pkg.sv =====
// Shared types, constants and helper functions for the dune feature extractor.
// Used by pdfe_alu and profile_dune_feature_extractor; depends on nothing else.
package pdfe_pkg;

  localparam int COORD_W    = 32;
  localparam int MUL_W      = 66;
  localparam int OPB_W      = 36;
  localparam int Q_W        = 49;
  localparam int ROOT_W     = 33;
  localparam int REM_W      = 38;
  localparam int CNT_W      = 6;
  localparam int DIV_STEPS  = 49;
  localparam int SQRT_STEPS = 33;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT, ST_EMIT} state_t;

  typedef enum logic [4:0] {
    SP_LX2, SP_LY2, SP_LAM, SP_AX2, SP_AY2, SP_DIST, SP_SLOPE, SP_TREND,
    SP_SLA, SP_SLB, SP_DX2, SP_DY2, SP_DMAG, SP_CD, SP_LHS, SP_P1, SP_P2
  } step_t;

  typedef enum logic [2:0] {
    KIND_MIN, KIND_MAX, KIND_SEG, KIND_SHORT, KIND_LONG
  } kind_t;

  typedef enum logic [2:0] {
    REG_MIN_RISE, REG_MIN_TREND, REG_DIR_X, REG_DIR_Y, REG_COS_TOL
  } reg_idx_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [50:0] sx51(input logic signed [32:0] v);
    return {{18{v[32]}}, v};
  endfunction

  function automatic logic signed [31:0] q16_fix(input logic [Q_W-1:0] q, input logic neg);
    logic [31:0] qs;
    logic        big;
    qs  = {1'b0, q[30:0]};
    big = |q[Q_W-1:31];
    if (neg) return big ? 32'sh80000000 : $signed(32'(32'd0 - qs));
    return big ? 32'sh7FFFFFFF : $signed(qs);
  endfunction

  function automatic logic signed [31:0] q16_zero(input logic signed [32:0] n);
    if (n > 33'sd0) return 32'sh7FFFFFFF;
    if (n < 33'sd0) return 32'sh80000000;
    return 32'sd0;
  endfunction

  function automatic logic signed [31:0] sat32w(input logic signed [50:0] v);
    if (v > 51'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -51'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] clamp_ext(input logic signed [34:0] v);
    if (v[34]) return 32'd0;
    if (|v[33:32]) return 32'hFFFFFFFF;
    return v[31:0];
  endfunction

endpackage

// ===== src/profile_dune_feature_extractor.sv =====
// Dune feature extractor: per-sample window and extremum tracking, serial feature maths.
// Depends on pdfe_pkg and pdfe_alu.
// A sample that is not a qualifying minimum only updates the window and extremum tracking;
// a minimum runs up to 17 serial steps on the shared unit (each a multiply, divide or square
// root) and, if it qualifies, hands out five records, waiting while the receiver holds off.
// One item at a time.
// Synchronous active-low reset restores the register defaults and clears all tracking state.
module profile_dune_feature_extractor import pdfe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_track_id,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_elev,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_record_kind,
  output logic [15:0]         out_track_number,
  output logic [31:0]         out_segment_number,
  output logic signed [31:0]  out_point_x,
  output logic signed [31:0]  out_point_y,
  output logic signed [31:0]  out_point_z,
  output logic signed [31:0]  out_end_x,
  output logic signed [31:0]  out_end_y,
  output logic [31:0]         out_extent,
  output logic signed [31:0]  out_gradient,
  output logic signed [31:0]  out_height_diff,
  output logic                out_last,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [20:0]         cfg_wdata
);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  kind_t  rec_r, rec_nxt;

  logic [19:0]        rise_r;
  logic signed [20:0] mth_r;
  logic signed [15:0] dx_r, dy_r, ct_r;

  logic [15:0]        cur_r, cur_nxt;
  logic               fmf_r, fmf_nxt;
  logic signed [31:0] win_r [9];
  logic signed [31:0] win_nxt [9];
  logic signed [31:0] fm_r [3];
  logic signed [31:0] fm_nxt [3];
  logic signed [31:0] pm_r [3];
  logic signed [31:0] pm_nxt [3];
  logic signed [31:0] mx_r [3];
  logic signed [31:0] mx_nxt [3];
  logic [31:0]        seg_r, seg_nxt;

  logic signed [32:0] lx_r, ly_r, ax_r, ay_r, dzm_r, dza_r, dzb_r;
  logic signed [32:0] lx_nxt, ly_nxt, ax_nxt, ay_nxt, dzm_nxt, dza_nxt, dzb_nxt;
  logic [65:0]        sq_r, sq_nxt;
  logic [32:0]        lam_r, lam_nxt, dist_r, dist_nxt;
  logic signed [31:0] slope_r, slope_nxt, sla_r, sla_nxt, slb_r, slb_nxt;
  logic signed [50:0] dzt_r, dzt_nxt;
  logic [15:0]        dmag_r, dmag_nxt;
  logic [30:0]        cd_r, cd_nxt;
  logic [63:0]        lhs_r, lhs_nxt;
  logic signed [50:0] p1_r, p1_nxt;

  logic               out_valid_r, out_valid_nxt, out_load;
  logic [2:0]         o_kind_r;
  logic [15:0]        o_trk_r;
  logic [31:0]        o_seg_r, o_ext_r;
  logic signed [31:0] o_px_r, o_py_r, o_pz_r, o_ex_r, o_ey_r, o_gr_r, o_hd_r;
  logic               o_last_r;

  alu_req_t           req;
  logic [MUL_W-1:0]   opa, alu_res;
  logic [OPB_W-1:0]   opb;
  logic               alu_busy;

  logic signed [32:0] dz1_c, dz2_c, rise_s;
  logic               is_min_c;
  logic [48:0]        t_c;
  logic signed [50:0] ts_c, dzt_c, p2_c, s_c;
  logic [50:0]        magdot_c;
  logic [64:0]        rhs_c;
  logic               trend_ok_c, dir_free_c, dir_ok_c, swap_c;
  logic signed [34:0] extb_c, exta_c;

  logic [2:0]         r_kind;
  logic [31:0]        r_seg, r_ext;
  logic signed [31:0] r_px, r_py, r_pz, r_ex, r_ey, r_gr, r_hd;
  logic               r_last;

  pdfe_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .busy   (alu_busy),
    .result (alu_res)
  );

  // decisions
  always_comb begin
    rise_s     = $signed({13'b0, rise_r});
    dz1_c      = 33'(win_r[5]) - 33'(win_r[8]);
    dz2_c      = 33'(in_elev) - 33'(win_r[8]);
    is_min_c   = (in_track_id == cur_r) && fmf_r && (in_elev < mx_r[2]) &&
                 (dz1_c > rise_s) && (dz2_c > rise_s);
    t_c        = alu_res[64:16];
    ts_c       = slope_r[31] ? -$signed({2'b00, t_c}) : $signed({2'b00, t_c});
    dzt_c      = sx51(dza_r) - ts_c;
    trend_ok_c = dzt_c > $signed({{30{mth_r[20]}}, mth_r});
    dir_free_c = (lam_r == '0) || (alu_res[15:0] == '0) || (ct_r <= 16'sd0);
    p2_c       = (ly_r[32] ^ dy_r[15]) ? -$signed({2'b00, alu_res[48:0]})
                                       : $signed({2'b00, alu_res[48:0]});
    s_c        = p1_r + p2_c;
    magdot_c   = s_c[50] ? 51'(-s_c) : 51'(s_c);
    rhs_c      = {magdot_c[49:0], 15'b0};
    dir_ok_c   = 65'(lhs_r) <= rhs_c;
    exta_c     = $signed({2'b00, dist_r});
    extb_c     = $signed({2'b00, lam_r}) - exta_c;
    swap_c     = extb_c > exta_c;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && is_min_c) begin
          state_nxt = ST_LAUNCH;
          step_nxt  = SP_LX2;
        end
      end
      ST_LAUNCH: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (!alu_busy) begin
          step_nxt  = step_t'(step_r + 5'd1);
          state_nxt = ST_LAUNCH;
          case (step_r)
            SP_TREND: if (!trend_ok_c) state_nxt = ST_IDLE;
            SP_DMAG:  if (dir_free_c) state_nxt = ST_EMIT;
            SP_P2:    state_nxt = dir_ok_c ? ST_EMIT : ST_IDLE;
            default:  state_nxt = ST_LAUNCH;
          endcase
        end
      end
      ST_EMIT: begin
        if ((!out_valid_r || out_ready) && rec_r == KIND_LONG) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req      = '{start: 1'b0, op: OP_MUL};
    opa      = '0;
    opb      = '0;
    out_load = 1'b0;
    rec_nxt  = rec_r;
    cur_nxt  = cur_r;
    fmf_nxt  = fmf_r;
    seg_nxt  = seg_r;
    for (int i = 0; i < 9; i++) win_nxt[i] = win_r[i];
    for (int i = 0; i < 3; i++) begin
      fm_nxt[i] = fm_r[i];
      pm_nxt[i] = pm_r[i];
      mx_nxt[i] = mx_r[i];
    end
    lx_nxt = lx_r;   ly_nxt = ly_r;   ax_nxt = ax_r;   ay_nxt = ay_r;
    dzm_nxt = dzm_r; dza_nxt = dza_r; dzb_nxt = dzb_r;
    sq_nxt = sq_r;   lam_nxt = lam_r; dist_nxt = dist_r;
    slope_nxt = slope_r; sla_nxt = sla_r; slb_nxt = slb_r;
    dzt_nxt = dzt_r; dmag_nxt = dmag_r; cd_nxt = cd_r; lhs_nxt = lhs_r; p1_nxt = p1_r;
    case (state_r)
      ST_IDLE: begin
        rec_nxt = KIND_MIN;
        if (in_valid) begin
          for (int i = 0; i < 6; i++) win_nxt[i] = win_r[i+3];
          win_nxt[6] = in_pos_x;
          win_nxt[7] = in_pos_y;
          win_nxt[8] = in_elev;
          if (in_track_id != cur_r) begin
            cur_nxt   = in_track_id;
            fmf_nxt   = 1'b0;
            fm_nxt[0] = in_pos_x;
            fm_nxt[1] = in_pos_y;
            fm_nxt[2] = in_elev;
          end else if (!fmf_r) begin
            if (in_elev <= fm_r[2]) begin
              fm_nxt[0] = in_pos_x;
              fm_nxt[1] = in_pos_y;
              fm_nxt[2] = in_elev;
            end else begin
              fmf_nxt = 1'b1;
              for (int i = 0; i < 3; i++) pm_nxt[i] = fm_r[i];
              mx_nxt[0] = in_pos_x;
              mx_nxt[1] = in_pos_y;
              mx_nxt[2] = in_elev;
            end
          end else if (in_elev >= mx_r[2]) begin
            mx_nxt[0] = in_pos_x;
            mx_nxt[1] = in_pos_y;
            mx_nxt[2] = in_elev;
          end else if (is_min_c) begin
            lx_nxt  = 33'(win_r[6]) - 33'(pm_r[0]);
            ly_nxt  = 33'(win_r[7]) - 33'(pm_r[1]);
            ax_nxt  = 33'(mx_r[0]) - 33'(pm_r[0]);
            ay_nxt  = 33'(mx_r[1]) - 33'(pm_r[1]);
            dzm_nxt = 33'(win_r[8]) - 33'(pm_r[2]);
            dza_nxt = 33'(mx_r[2]) - 33'(pm_r[2]);
            dzb_nxt = 33'(mx_r[2]) - 33'(win_r[8]);
          end
        end
      end
      ST_LAUNCH: begin
        req.start = 1'b1;
        case (step_r)
          SP_LX2:   begin opa = MUL_W'(mag33(lx_r)); opb = OPB_W'(mag33(lx_r)); end
          SP_LY2:   begin opa = MUL_W'(mag33(ly_r)); opb = OPB_W'(mag33(ly_r)); end
          SP_LAM:   begin req.op = OP_SQRT; opa = sq_r; end
          SP_AX2:   begin opa = MUL_W'(mag33(ax_r)); opb = OPB_W'(mag33(ax_r)); end
          SP_AY2:   begin opa = MUL_W'(mag33(ay_r)); opb = OPB_W'(mag33(ay_r)); end
          SP_DIST:  begin req.op = OP_SQRT; opa = sq_r; end
          SP_SLOPE: begin
            req.op = OP_DIV;
            opa    = MUL_W'({mag33(dzm_r), 16'b0});
            opb    = OPB_W'(lam_r);
          end
          SP_TREND: begin opa = MUL_W'(dist_r); opb = OPB_W'(mag32(slope_r)); end
          SP_SLA: begin
            req.op = OP_DIV;
            opa    = MUL_W'({mag33(dza_r), 16'b0});
            opb    = OPB_W'(dist_r);
          end
          SP_SLB: begin
            req.op = OP_DIV;
            opa    = MUL_W'({mag33(dzb_r), 16'b0});
            opb    = extb_c[34] ? OPB_W'(-extb_c) : OPB_W'(extb_c);
          end
          SP_DX2:   begin opa = MUL_W'(mag16(dx_r)); opb = OPB_W'(mag16(dx_r)); end
          SP_DY2:   begin opa = MUL_W'(mag16(dy_r)); opb = OPB_W'(mag16(dy_r)); end
          SP_DMAG:  begin req.op = OP_SQRT; opa = sq_r; end
          SP_CD:    begin opa = MUL_W'(mag16(ct_r)); opb = OPB_W'(dmag_r); end
          SP_LHS:   begin opa = MUL_W'(lam_r); opb = OPB_W'(cd_r); end
          SP_P1:    begin opa = MUL_W'(mag33(lx_r)); opb = OPB_W'(mag16(dx_r)); end
          SP_P2:    begin opa = MUL_W'(mag33(ly_r)); opb = OPB_W'(mag16(dy_r)); end
          default:  req.start = 1'b0;
        endcase
      end
      ST_WAIT: begin
        if (!alu_busy) begin
          case (step_r)
            SP_LX2, SP_AX2, SP_DX2: sq_nxt = alu_res;
            SP_LY2, SP_AY2, SP_DY2: sq_nxt = sq_r + alu_res;
            SP_LAM:   lam_nxt  = alu_res[32:0];
            SP_DIST:  dist_nxt = alu_res[32:0];
            SP_SLOPE: slope_nxt = (lam_r == '0) ? q16_zero(dzm_r)
                                                : q16_fix(alu_res[48:0], dzm_r[32]);
            SP_TREND: dzt_nxt = dzt_c;
            SP_SLA:   sla_nxt = (dist_r == '0) ? q16_zero(dza_r)
                                               : q16_fix(alu_res[48:0], dza_r[32]);
            SP_SLB:   slb_nxt = (extb_c == '0) ? q16_zero(dzb_r)
                                : q16_fix(alu_res[48:0], dzb_r[32] ^ extb_c[34]);
            SP_DMAG:  dmag_nxt = alu_res[15:0];
            SP_CD:    cd_nxt = alu_res[30:0];
            SP_LHS:   lhs_nxt = alu_res[63:0];
            SP_P1:    p1_nxt = (lx_r[32] ^ dx_r[15]) ? -$signed({2'b00, alu_res[48:0]})
                                                     : $signed({2'b00, alu_res[48:0]});
            SP_P2: begin
              if (!dir_ok_c) begin
                for (int i = 0; i < 3; i++) begin
                  pm_nxt[i] = win_r[i+3];
                  mx_nxt[i] = win_r[i+3];
                end
              end
            end
            default: sq_nxt = sq_r;
          endcase
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          case (rec_r)
            KIND_MIN:   rec_nxt = KIND_MAX;
            KIND_MAX:   rec_nxt = KIND_SEG;
            KIND_SEG:   rec_nxt = KIND_SHORT;
            KIND_SHORT: rec_nxt = KIND_LONG;
            default:    rec_nxt = KIND_MIN;
          endcase
          if (rec_r != KIND_MIN && rec_r != KIND_MAX) seg_nxt = seg_r + 32'd1;
          if (rec_r == KIND_LONG) begin
            for (int i = 0; i < 3; i++) begin
              pm_nxt[i] = win_r[i+3];
              mx_nxt[i] = win_r[i+3];
            end
          end
        end
      end
      default: rec_nxt = KIND_MIN;
    endcase
  end

  // record select
  always_comb begin
    r_kind = 3'(rec_r);
    r_seg  = '0;
    r_px   = mx_r[0];
    r_py   = mx_r[1];
    r_pz   = '0;
    r_ex   = '0;
    r_ey   = '0;
    r_ext  = '0;
    r_gr   = '0;
    r_hd   = '0;
    r_last = 1'b0;
    case (rec_r)
      KIND_MIN: begin
        r_px  = pm_r[0];
        r_py  = pm_r[1];
        r_pz  = pm_r[2];
        r_ext = clamp_ext($signed({2'b00, lam_r}));
        r_gr  = slope_r;
        r_hd  = sat32w(sx51(dzm_r));
      end
      KIND_MAX: begin
        r_pz = mx_r[2];
        r_hd = sat32w(dzt_r);
      end
      KIND_SEG: begin
        r_seg = seg_r + 32'd1;
        r_px  = pm_r[0];
        r_py  = pm_r[1];
        r_ex  = win_r[3];
        r_ey  = win_r[4];
        r_ext = clamp_ext($signed({2'b00, lam_r}));
        r_gr  = (slope_r == 32'sh80000000) ? 32'sh7FFFFFFF : $signed(mag32(slope_r));
        r_hd  = sat32w($signed({18'b0, mag33(dzm_r)}));
      end
      KIND_SHORT: begin
        r_seg = seg_r + 32'd1;
        r_ex  = swap_c ? pm_r[0] : win_r[3];
        r_ey  = swap_c ? pm_r[1] : win_r[4];
        r_ext = clamp_ext(swap_c ? exta_c : extb_c);
        r_gr  = swap_c ? sla_r : slb_r;
        r_hd  = sat32w(sx51(swap_c ? dza_r : dzb_r));
      end
      KIND_LONG: begin
        r_seg  = seg_r + 32'd1;
        r_ex   = swap_c ? win_r[3] : pm_r[0];
        r_ey   = swap_c ? win_r[4] : pm_r[1];
        r_ext  = clamp_ext(swap_c ? extb_c : exta_c);
        r_gr   = swap_c ? slb_r : sla_r;
        r_hd   = sat32w(sx51(swap_c ? dzb_r : dza_r));
        r_last = 1'b1;
      end
      default: r_last = 1'b0;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_LX2;
      rec_r       <= KIND_MIN;
      out_valid_r <= 1'b0;
      rise_r      <= 20'd51;
      mth_r       <= '0;
      dx_r        <= '0;
      dy_r        <= 16'sd32767;
      ct_r        <= 16'sd32767;
      cur_r       <= '0;
      fmf_r       <= 1'b0;
      seg_r       <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        fm_r[i] <= '0;
        pm_r[i] <= '0;
        mx_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      rec_r       <= rec_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      fmf_r       <= fmf_nxt;
      seg_r       <= seg_nxt;
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
      for (int i = 0; i < 3; i++) begin
        fm_r[i] <= fm_nxt[i];
        pm_r[i] <= pm_nxt[i];
        mx_r[i] <= mx_nxt[i];
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_RISE:  rise_r <= cfg_wdata[19:0];
          REG_MIN_TREND: mth_r  <= cfg_wdata;
          REG_DIR_X:     dx_r   <= cfg_wdata[15:0];
          REG_DIR_Y:     dy_r   <= cfg_wdata[15:0];
          REG_COS_TOL:   ct_r   <= cfg_wdata[15:0];
          default:       rise_r <= rise_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lx_r <= lx_nxt;   ly_r <= ly_nxt;   ax_r <= ax_nxt;   ay_r <= ay_nxt;
    dzm_r <= dzm_nxt; dza_r <= dza_nxt; dzb_r <= dzb_nxt;
    sq_r <= sq_nxt;   lam_r <= lam_nxt; dist_r <= dist_nxt;
    slope_r <= slope_nxt; sla_r <= sla_nxt; slb_r <= slb_nxt;
    dzt_r <= dzt_nxt; dmag_r <= dmag_nxt; cd_r <= cd_nxt; lhs_r <= lhs_nxt; p1_r <= p1_nxt;
    if (out_load) begin
      o_kind_r <= r_kind;
      o_trk_r  <= cur_r;
      o_seg_r  <= r_seg;
      o_px_r   <= r_px;
      o_py_r   <= r_py;
      o_pz_r   <= r_pz;
      o_ex_r   <= r_ex;
      o_ey_r   <= r_ey;
      o_ext_r  <= r_ext;
      o_gr_r   <= r_gr;
      o_hd_r   <= r_hd;
      o_last_r <= r_last;
    end
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_record_kind    = o_kind_r;
  assign out_track_number   = o_trk_r;
  assign out_segment_number = o_seg_r;
  assign out_point_x        = o_px_r;
  assign out_point_y        = o_py_r;
  assign out_point_z        = o_pz_r;
  assign out_end_x          = o_ex_r;
  assign out_end_y          = o_ey_r;
  assign out_extent         = o_ext_r;
  assign out_gradient       = o_gr_r;
  assign out_height_diff    = o_hd_r;
  assign out_last           = o_last_r;

  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !alu_busy) else $error("unit busy while taking items");

  a_launch_starts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LAUNCH |=> alu_busy) else $error("unit did not start");

  a_last_is_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_record_kind == KIND_LONG) else $error("last flag misplaced");

  a_seg_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && rec_r == KIND_SEG |=> seg_r == $past(seg_r) + 32'd1)
    else $error("segment counter did not advance");

endmodule

// ===== src/pdfe_alu.sv =====
// Shared bit-serial unit: shift-add multiply, restoring divide, digit square root.
// Depends on pdfe_pkg; used by profile_dune_feature_extractor.
module pdfe_alu import pdfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  alu_req_t         req,
  input  logic [MUL_W-1:0] opa,
  input  logic [OPB_W-1:0] opb,
  output logic             busy,
  output logic [MUL_W-1:0] result
);

  logic             busy_r, busy_nxt;
  op_t              op_r, op_nxt;
  logic [MUL_W-1:0] x_r, x_nxt;
  logic [OPB_W-1:0] y_r, y_nxt;
  logic [MUL_W-1:0] acc_r, acc_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] r2, dv;
  logic             ge;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    r2       = '0;
    dv       = '0;
    ge       = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      x_nxt    = opa;
      y_nxt    = opb;
      acc_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = (req.op == OP_DIV) ? CNT_W'(DIV_STEPS) : CNT_W'(SQRT_STEPS);
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          if (y_r == '0) begin
            busy_nxt = 1'b0;
          end else begin
            if (y_r[0]) acc_nxt = acc_r + x_r;
            x_nxt = x_r << 1;
            y_nxt = y_r >> 1;
          end
        end
        OP_DIV: begin
          r2      = {rem_r[REM_W-2:0], x_r[Q_W-1]};
          dv      = REM_W'(y_r);
          ge      = (r2 >= dv);
          rem_nxt = ge ? (r2 - dv) : r2;
          q_nxt   = {q_r[Q_W-2:0], ge};
          x_nxt   = x_r << 1;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
        end
        OP_SQRT: begin
          r2      = {rem_r[REM_W-3:0], x_r[MUL_W-1:MUL_W-2]};
          dv      = {3'b000, q_r[ROOT_W-1:0], 2'b01};
          ge      = (r2 >= dv);
          rem_nxt = ge ? (r2 - dv) : r2;
          q_nxt   = {q_r[Q_W-2:0], ge};
          x_nxt   = x_r << 2;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy   = busy_r;
  assign result = (op_r == OP_MUL) ? acc_r : MUL_W'(q_r);

endmodule

// ===== tb/sv/tb_profile_dune_feature_extractor.sv =====
// Self-checking testbench for profile_dune_feature_extractor: drives dune-shaped survey tracks
// and noise, predicts every record with a local bit-accurate model, checks each record in order.
// Depends on pdfe_pkg and the extractor RTL only.
`timescale 1ns / 1ps

module tb_profile_dune_feature_extractor;
  import pdfe_pkg::*;

  localparam int ITEMS = 280;
  localparam int SETTLE = 1000;
  localparam int WDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] trk;
    logic [31:0] seg, px, py, pz, ex, ey, ext, grad, hd;
    logic        last;
  } rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_track_id = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_elev = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_record_kind;
  logic [15:0] out_track_number;
  logic [31:0] out_segment_number, out_extent;
  logic signed [31:0] out_point_x, out_point_y, out_point_z, out_end_x, out_end_y;
  logic signed [31:0] out_gradient, out_height_diff;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [20:0] cfg_wdata = '0;

  profile_dune_feature_extractor i_dut (.*);

  // predictor state
  logic [19:0] rise_cfg;
  logic signed [20:0] trend_cfg;
  logic signed [15:0] azx_cfg, azy_cfg, tol_cfg;
  longint win_buf[9];
  logic [15:0] trk_now;
  bit fmin_found;
  longint fmin_pt[3], pmin_pt[3], peak_pt[3];
  logic [31:0] seg_cnt;
  rec_t rec_due[$];

  int errs = 0;
  int n_sent = 0;
  int idle_cyc = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_token = 0;
  int hold_seen = 0;
  int rx_wait = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] umag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] sq2(longint a, longint b);
    return 128'(umag(a)) * 128'(umag(a)) + 128'(umag(b)) * 128'(umag(b));
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] s);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= s) r = c;
    end
    return r;
  endfunction

  function automatic longint q16div(longint num, longint den);
    logic [63:0] nm, dm;
    logic [127:0] q;
    nm = umag(num);
    dm = umag(den);
    if (dm == 0) return num > 0 ? S32_MAX : (num < 0 ? S32_MIN : 0);
    q = (128'(nm) << 16) / 128'(dm);
    if ((num < 0) != (den < 0)) return q >= 128'h80000000 ? S32_MIN : -longint'(q[63:0]);
    return q > 128'h7FFFFFFF ? S32_MAX : longint'(q[63:0]);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > S32_MAX) return 32'h7FFFFFFF;
    if (v < S32_MIN) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic rec_t mk_rec(kind_t k, logic [31:0] sg, longint px, longint py, longint pz,
                                  longint ex, longint ey, longint ext, longint grd, longint hd,
                                  logic lst);
    rec_t r;
    r.kind = k;
    r.trk = trk_now;
    r.seg = sg;
    r.px = px[31:0];
    r.py = py[31:0];
    r.pz = pz[31:0];
    r.ex = ex[31:0];
    r.ey = ey[31:0];
    r.ext = ext < 0 ? 32'd0 : (ext > 64'sd4294967295 ? 32'hFFFFFFFF : ext[31:0]);
    r.grad = sat32(grd);
    r.hd = sat32(hd);
    r.last = lst;
    return r;
  endfunction

  function automatic bit aim_ok(longint lx, longint ly, logic [63:0] lam);
    longint dx, dy, ct, s;
    logic [63:0] md, dmag;
    dx = azx_cfg;
    dy = azy_cfg;
    ct = tol_cfg;
    s = lx * dx + ly * dy;
    md = umag(s);
    dmag = isqrt(sq2(dx, dy));
    if (lam == 0 || dmag == 0 || ct <= 0) return 1'b1;
    return 128'(64'(ct) * dmag) * 128'(lam) <= 128'(md) * 128'(32768);
  endfunction

  function automatic void score_trough();
    longint lx, ly, ax, ay, dzm, slope, ts, dza, dzb, dzt, exta, extb, sla, slb;
    longint lext, lsl, lhd, sxt, ssl, shd, lpx, lpy, spx, spy;
    logic [63:0] lam, span, t;
    logic [127:0] p;
    lx = win_buf[3] - pmin_pt[0];
    ly = win_buf[4] - pmin_pt[1];
    ax = peak_pt[0] - pmin_pt[0];
    ay = peak_pt[1] - pmin_pt[1];
    lam = isqrt(sq2(lx, ly));
    span = isqrt(sq2(ax, ay));
    dzm = win_buf[5] - pmin_pt[2];
    slope = q16div(dzm, longint'(lam));
    p = 128'(umag(slope)) * 128'(span);
    t = p[79:16];
    ts = slope < 0 ? -longint'(t) : longint'(t);
    dza = peak_pt[2] - pmin_pt[2];
    dzb = peak_pt[2] - win_buf[5];
    dzt = dza - ts;
    exta = longint'(span);
    extb = longint'(lam) - longint'(span);
    sla = q16div(dza, exta);
    slb = q16div(dzb, extb);
    if (!(dzt > longint'(trend_cfg))) return;
    if (extb > exta) begin
      lpx = win_buf[3]; lpy = win_buf[4]; spx = pmin_pt[0]; spy = pmin_pt[1];
      lext = extb; lsl = slb; lhd = dzb; sxt = exta; ssl = sla; shd = dza;
    end else begin
      lpx = pmin_pt[0]; lpy = pmin_pt[1]; spx = win_buf[3]; spy = win_buf[4];
      lext = exta; lsl = sla; lhd = dza; sxt = extb; ssl = slb; shd = dzb;
    end
    if (aim_ok(lx, ly, lam)) begin
      rec_due.push_back(mk_rec(KIND_MIN, 0, pmin_pt[0], pmin_pt[1], pmin_pt[2], 0, 0,
                               longint'(lam), slope, dzm, 1'b0));
      rec_due.push_back(mk_rec(KIND_MAX, 0, peak_pt[0], peak_pt[1], peak_pt[2], 0, 0,
                               0, 0, dzt, 1'b0));
      seg_cnt = seg_cnt + 1;
      rec_due.push_back(mk_rec(KIND_SEG, seg_cnt, pmin_pt[0], pmin_pt[1], 0, win_buf[3],
                               win_buf[4], longint'(lam), longint'(umag(slope)),
                               longint'(umag(dzm)), 1'b0));
      seg_cnt = seg_cnt + 1;
      rec_due.push_back(mk_rec(KIND_SHORT, seg_cnt, peak_pt[0], peak_pt[1], 0, spx, spy,
                               sxt, ssl, shd, 1'b0));
      seg_cnt = seg_cnt + 1;
      rec_due.push_back(mk_rec(KIND_LONG, seg_cnt, peak_pt[0], peak_pt[1], 0, lpx, lpy,
                               lext, lsl, lhd, 1'b1));
    end
    for (int i = 0; i < 3; i++) begin
      pmin_pt[i] = win_buf[3 + i];
      peak_pt[i] = win_buf[3 + i];
    end
  endfunction

  function automatic void dune_predict(logic [15:0] tid, logic signed [31:0] px,
                                       logic signed [31:0] py, logic signed [31:0] pz);
    longint v[3];
    v[0] = px;
    v[1] = py;
    v[2] = pz;
    for (int i = 0; i < 6; i++) win_buf[i] = win_buf[i + 3];
    for (int i = 0; i < 3; i++) win_buf[6 + i] = v[i];
    if (tid != trk_now) begin
      trk_now = tid;
      fmin_found = 1'b0;
      fmin_pt = v;
      return;
    end
    if (!fmin_found) begin
      if (v[2] <= fmin_pt[2]) begin
        fmin_pt = v;
      end else begin
        fmin_found = 1'b1;
        pmin_pt = fmin_pt;
        peak_pt = v;
      end
      return;
    end
    if (v[2] >= peak_pt[2]) begin
      peak_pt = v;
      return;
    end
    if (win_buf[2] - win_buf[5] > longint'(rise_cfg) &&
        win_buf[8] - win_buf[5] > longint'(rise_cfg)) score_trough();
  endfunction

  function automatic void model_reset();
    rise_cfg = 20'd51;
    trend_cfg = '0;
    azx_cfg = '0;
    azy_cfg = 16'sd32767;
    tol_cfg = 16'sd32767;
    foreach (win_buf[i]) win_buf[i] = 0;
    for (int i = 0; i < 3; i++) begin
      fmin_pt[i] = 0; pmin_pt[i] = 0; peak_pt[i] = 0;
    end
    trk_now = '0;
    fmin_found = 1'b0;
    seg_cnt = '0;
  endfunction

  function automatic void cmp_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s expected %h actual %h", nm, e, a);
      errs++;
    end
  endfunction

  always @(negedge clk) begin : rec_check
    rec_t e;
    if (rst_n && out_valid && out_ready) begin
      if (rec_due.size() == 0) begin
        $error("record_kind expected none actual %0d", out_record_kind);
        errs++;
      end else begin
        e = rec_due.pop_front();
        cmp_field("record_kind", 32'(e.kind), 32'(out_record_kind));
        cmp_field("track_number", 32'(e.trk), 32'(out_track_number));
        cmp_field("segment_number", e.seg, out_segment_number);
        cmp_field("point_x", e.px, out_point_x);
        cmp_field("point_y", e.py, out_point_y);
        cmp_field("point_z", e.pz, out_point_z);
        cmp_field("end_x", e.ex, out_end_x);
        cmp_field("end_y", e.ey, out_end_y);
        cmp_field("extent", e.ext, out_extent);
        cmp_field("gradient", e.grad, out_gradient);
        cmp_field("height_diff", e.hd, out_height_diff);
        cmp_field("last", 32'(e.last), 32'(out_last));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= WDOG_LIMIT) begin
        $display("FAIL profile_dune_feature_extractor");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      rx_wait <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      rx_wait <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [15:0] tid, input longint x, input longint y,
                             input longint z);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_track_id <= tid;
    in_pos_x <= 32'(x);
    in_pos_y <= 32'(y);
    in_elev <= 32'(z);
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    dune_predict(tid, 32'(x), 32'(y), 32'(z));
    n_sent++;
  endtask

  task automatic send_noise();
    send_sample(16'($urandom()), longint'($signed($urandom())),
                longint'($signed($urandom())), longint'($signed($urandom())));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (rec_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MIN_RISE:  rise_cfg = val[19:0];
      REG_MIN_TREND: trend_cfg = val;
      REG_DIR_X:     azx_cfg = val[15:0];
      REG_DIR_Y:     azy_cfg = val[15:0];
      REG_COS_TOL:   tol_cfg = val[15:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [20:0] rise, input logic [20:0] trend,
                          input logic [20:0] ax, input logic [20:0] ay, input logic [20:0] tol);
    wait_idle();
    write_reg(REG_MIN_RISE, rise);
    write_reg(REG_MIN_TREND, trend);
    write_reg(REG_DIR_X, ax);
    write_reg(REG_DIR_Y, ay);
    write_reg(REG_COS_TOL, tol);
  endtask

  // start high, fall to a trough, then rise and fall nd times; troughs jitter upwards
  task automatic run_dunes(input logic [15:0] tid, input longint x0, input longint y0,
                           input longint sx, input longint sy, input longint z0,
                           input longint zs, input int nd, input int k, input int jit);
    longint x, y, tz;
    x = x0;
    y = y0;
    tz = z0;
    send_sample(tid, x, y, z0 + k * zs);
    for (int d = 0; d <= nd; d++) begin
      tz = z0 + $urandom_range(0, jit);
      for (int j = 1; j <= k; j++) begin
        x += sx; y += sy;
        send_sample(tid, x, y, tz + (k - j) * zs);
      end
      for (int j = 1; j <= (d == nd ? 1 : k); j++) begin
        x += sx; y += sy;
        send_sample(tid, x, y, tz + j * zs);
      end
    end
  endtask

  task automatic random_dunes();
    logic [15:0] tid;
    longint zs;
    tid = ($urandom_range(0, 3) == 0) ? trk_now : 16'($urandom());
    zs = longint'(rise_cfg) + 1 + $urandom_range(0, 1 << 20);
    run_dunes(tid, longint'($signed($urandom())), longint'($signed($urandom())),
              longint'($urandom_range(0, 8192)) - 4096, longint'($urandom_range(0, 8192)) - 4096,
              longint'($urandom_range(0, 1 << 29)) - (1 << 28), zs,
              $urandom_range(1, 3), $urandom_range(2, 4), int'(zs / 2));
  endtask

  task automatic test_directed();
    send_sample(16'h0000, 0, 0, 0);
    send_sample(16'hFFFF, S32_MAX, S32_MIN, S32_MAX);
    send_sample(16'h0000, S32_MIN, S32_MAX, S32_MIN);
    run_dunes(16'h0001, 0, 0, 0, 1024, 0, 4096, 1, 2, 0);
    run_dunes(16'h0002, 100, 100, 0, 0, 0, 4096, 1, 2, 0);
    run_dunes(16'hFFFF, S32_MIN, S32_MIN, 0, 1 << 30, S32_MIN, S32_MAX, 1, 2, 0);
  endtask

  task automatic test_config_extremes();
    set_regs(21'd0, 21'h100000, 21'h007FFF, 21'h000000, 21'h000000);
    write_reg(REG_SPARE_LO, 21'($urandom()));
    write_reg(REG_SPARE_HI, 21'($urandom()));
    repeat (2) random_dunes();
    set_regs(21'h0FFFFF, 21'h0FFFFF, 21'h008000, 21'h008000, 21'h008000);
    repeat (2) random_dunes();
    set_regs(21'd51, 21'h1FFF00, 21'h000000, 21'h000000, 21'h007FFF);
    repeat (2) random_dunes();
  endtask

  task automatic test_pressure();
    set_regs(21'd200, 21'h1FF000, 21'h005A82, 21'h005A82, 21'h002000);
    hold_token <= hold_token + 1;
    repeat (3) random_dunes();
    in_valid <= 1'b0;
    wait (rec_due.size() == 0);
    @(posedge clk);
    random_dunes();
  endtask

  task automatic test_random(input int upto);
    while (n_sent < upto) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) send_noise();
      else random_dunes();
      if ($urandom_range(0, 9) == 0) begin
        tx_gaps = $urandom_range(0, 1);
        rx_gaps = $urandom_range(0, 1);
      end
    end
  endtask

  task automatic test_quiet_tail();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (3) random_dunes();
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_pressure();
    set_regs(21'($urandom_range(0, 4096)), 21'($urandom_range(0, 2048)),
             21'($urandom()), 21'($urandom()), 21'($urandom_range(0, 32767)));
    test_random(ITEMS / 2);
    set_regs(21'd51, 21'h1FFC00, 21'h000000, 21'h000000, 21'h000000);
    test_random(ITEMS - 30);
    test_quiet_tail();
    wait_idle();
    if (errs == 0) $display("PASS profile_dune_feature_extractor");
    else $display("FAIL profile_dune_feature_extractor");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pdfe_pkg.sv
src/pdfe_alu.sv
src/profile_dune_feature_extractor.sv
tb/sv/tb_profile_dune_feature_extractor.sv
